// ----- rtl/cdi_pkg.sv -----
// Shared constants, stage payload types and month helpers for the date increment pipeline.
`timescale 1ns / 1ps

package cdi_pkg;

  localparam logic [23:0] DATE_LOW    = 24'd1010001;
  localparam logic [23:0] DATE_HIGH   = 24'd12319999;
  localparam logic [23:0] MONTH_SCALE = 24'd1000000;
  localparam logic [13:0] DAY_SCALE   = 14'd10000;
  localparam logic [13:0] YEAR_LAST   = 14'd9999;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [3:0]  MONTH_DEC   = 4'd12;
  localparam int unsigned NUM_MONTHS  = 12;

  // floor(r / 10000) = (r * DAY_RECIP) >> DAY_SHIFT for every r below 2**20
  localparam logic [20:0] DAY_RECIP   = 21'd1717987;
  localparam int unsigned DAY_SHIFT   = 34;
  // floor(y / 100) = (y * CENT_RECIP) >> CENT_SHIFT for every y below 2**14
  localparam logic [14:0] CENT_RECIP  = 15'd20972;
  localparam int unsigned CENT_SHIFT  = 21;
  localparam logic [6:0]  CENT_SCALE  = 7'd100;

  typedef struct packed {
    logic [23:0] date;
    logic        bad;
    logic [3:0]  month;
    logic [6:0]  day;
    logic [13:0] year;
  } cdi_date_t;

  typedef struct packed {
    cdi_date_t f;
    logic      leap;
  } cdi_leap_t;

  // Month start offset in the packed word
  function automatic logic [23:0] month_base(input logic [3:0] m);
    return 24'(m) * MONTH_SCALE;
  endfunction

  // Length of a month, February given as its common-year length
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      MONTH_FEB:               len = 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/cdi_split.sv -----
// Four-stage split of the packed date into month, day and year with range check.
`timescale 1ns / 1ps

module cdi_split (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [23:0]        date_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cdi_pkg::cdi_date_t out_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [23:0] s1_date_q;
  logic        s1_bad_q;
  logic [3:0]  s1_month_q;
  logic [23:0] s2_date_q;
  logic        s2_bad_q;
  logic [3:0]  s2_month_q;
  logic [19:0] s2_rem_q;
  logic [23:0] s3_date_q;
  logic        s3_bad_q;
  logic [3:0]  s3_month_q;
  logic [19:0] s3_rem_q;
  logic [40:0] s3_prod_q;
  cdi_pkg::cdi_date_t s4_q;

  logic        bad_d;
  logic [3:0]  month_d;
  logic [19:0] rem_d;
  logic [40:0] prod_d;
  logic [6:0]  day_d;
  logic [13:0] year_d;

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Month by threshold compares, range check alongside
  always_comb begin
    bad_d   = (date_i < cdi_pkg::DATE_LOW) || (date_i > cdi_pkg::DATE_HIGH);
    month_d = '0;
    for (int k = 1; k <= cdi_pkg::NUM_MONTHS; k++) begin
      if (date_i >= cdi_pkg::month_base(4'(k))) begin
        month_d = 4'(k);
      end
    end
  end

  assign rem_d  = 20'(s1_date_q - cdi_pkg::month_base(s1_month_q));
  assign prod_d = 41'(s2_rem_q) * 41'(cdi_pkg::DAY_RECIP);
  assign day_d  = s3_prod_q[cdi_pkg::DAY_SHIFT +: 7];
  assign year_d = 14'(s3_rem_q - 20'(day_d) * 20'(cdi_pkg::DAY_SCALE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_date_q  <= date_i;
      s1_bad_q   <= bad_d;
      s1_month_q <= month_d;
    end
    if (rdy2 && v1_q) begin
      s2_date_q  <= s1_date_q;
      s2_bad_q   <= s1_bad_q;
      s2_month_q <= s1_month_q;
      s2_rem_q   <= rem_d;
    end
    if (rdy3 && v2_q) begin
      s3_date_q  <= s2_date_q;
      s3_bad_q   <= s2_bad_q;
      s3_month_q <= s2_month_q;
      s3_rem_q   <= s2_rem_q;
      s3_prod_q  <= prod_d;
    end
    if (rdy4 && v3_q) begin
      s4_q.date  <= s3_date_q;
      s4_q.bad   <= s3_bad_q;
      s4_q.month <= s3_month_q;
      s4_q.day   <= day_d;
      s4_q.year  <= year_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_o       = s4_q;

endmodule

// ----- rtl/cdi_leap.sv -----
// Two-stage Gregorian leap year test on the split year.
`timescale 1ns / 1ps

module cdi_leap (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cdi_pkg::cdi_date_t in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cdi_pkg::cdi_leap_t out_o
);

  logic v5_q, v6_q;
  logic rdy5, rdy6;

  cdi_pkg::cdi_date_t s5_q;
  logic [28:0]        s5_prod_q;
  cdi_pkg::cdi_leap_t s6_q;

  logic [28:0] prod_d;
  logic [6:0]  cent;
  logic        century;
  logic        leap_d;

  assign rdy6       = !v6_q || out_ready_i;
  assign rdy5       = !v5_q || rdy6;
  assign in_ready_o = rdy5;

  assign prod_d  = 29'(in_i.year) * 29'(cdi_pkg::CENT_RECIP);
  assign cent    = s5_prod_q[cdi_pkg::CENT_SHIFT +: 7];
  // whole century when the year equals its hundreds times one hundred
  assign century = (s5_q.year == 14'(cent) * 14'(cdi_pkg::CENT_SCALE));
  assign leap_d  = (s5_q.year[1:0] == 2'b00) && (!century || (cent[1:0] == 2'b00));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy5) v5_q <= in_valid_i;
      if (rdy6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && in_valid_i) begin
      s5_q      <= in_i;
      s5_prod_q <= prod_d;
    end
    if (rdy6 && v5_q) begin
      s6_q.f    <= s5_q;
      s6_q.leap <= leap_d;
    end
  end

  assign out_valid_o = v6_q;
  assign out_o       = s6_q;

endmodule

// ----- rtl/cdi_roll.sv -----
// Two-stage day roll-over decision and repacking of the result.
`timescale 1ns / 1ps

module cdi_roll (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cdi_pkg::cdi_leap_t in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [23:0]        next_date_o,
  output logic               not_well_formed_o,
  output logic               at_last_date_o
);

  logic v7_q, v8_q;
  logic rdy7, rdy8;

  logic [23:0] s7_date_q;
  logic        s7_pass_q;
  logic        s7_bad_q;
  logic        s7_last_q;
  logic [23:0] s7_base_q;
  logic [6:0]  s7_day_q;
  logic [13:0] s7_year_q;
  logic [23:0] s8_next_q;
  logic        s8_bad_q;
  logic        s8_last_q;

  logic [4:0]  mlen;
  logic [3:0]  month_d;
  logic [6:0]  day_d;
  logic [13:0] year_d;
  logic        last_d;
  logic [23:0] next_d;

  assign rdy8       = !v8_q || out_ready_i;
  assign rdy7       = !v7_q || rdy8;
  assign in_ready_o = rdy7;

  always_comb begin
    if (in_i.f.month == cdi_pkg::MONTH_FEB) begin
      mlen = in_i.leap ? 5'd29 : 5'd28;
    end else begin
      mlen = cdi_pkg::month_len(in_i.f.month);
    end
    month_d = in_i.f.month;
    day_d   = in_i.f.day;
    year_d  = in_i.f.year;
    last_d  = 1'b0;
    if (in_i.f.day < 7'(mlen)) begin
      day_d = in_i.f.day + 7'd1;
    end else if (in_i.f.month < cdi_pkg::MONTH_DEC) begin
      month_d = in_i.f.month + 4'd1;
      day_d   = 7'd1;
    end else if (in_i.f.year < cdi_pkg::YEAR_LAST) begin
      year_d  = in_i.f.year + 14'd1;
      month_d = 4'd1;
      day_d   = 7'd1;
    end else begin
      last_d  = 1'b1;
    end
  end

  assign next_d = s7_pass_q ? s7_date_q
                            : s7_base_q + 24'(s7_day_q) * 24'(cdi_pkg::DAY_SCALE)
                              + 24'(s7_year_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      if (rdy7) v7_q <= in_valid_i;
      if (rdy8) v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy7 && in_valid_i) begin
      s7_date_q <= in_i.f.date;
      s7_bad_q  <= in_i.f.bad;
      s7_last_q <= !in_i.f.bad && last_d;
      s7_pass_q <= in_i.f.bad || last_d;
      s7_base_q <= cdi_pkg::month_base(month_d);
      s7_day_q  <= day_d;
      s7_year_q <= year_d;
    end
    if (rdy8 && v7_q) begin
      s8_next_q <= next_d;
      s8_bad_q  <= s7_bad_q;
      s8_last_q <= s7_last_q;
    end
  end

  assign out_valid_o       = v8_q;
  assign next_date_o       = s8_next_q;
  assign not_well_formed_o = s8_bad_q;
  assign at_last_date_o    = s8_last_q;

endmodule

// ----- rtl/calendar_date_increment.sv -----
// Top level of the packed calendar date increment pipeline.
`timescale 1ns / 1ps

// Takes a date packed as the binary integer month*1000000 + day*10000 + year and
// returns the following day in the same packing, with Gregorian leap years.
// Inputs outside 1010001..12319999 come back unchanged with not_well_formed_o set;
// December 31 of year 9999 comes back unchanged with at_last_date_o set. A day of
// zero advances to the 1st, a day past the month length rolls into the next month.
// Throughput is one date per cycle while the output is not stalled. The eight
// register stages are month split, month remainder, day reciprocal product,
// day/year split, century reciprocal product, leap test, roll-over decision
// and repacking. Every stage has its own valid bit and accepts whenever it is
// empty or its successor takes its contents, so bubbles are squeezed out while
// the output is stalled.

module calendar_date_increment (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] packed_date_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] next_date_o,
  output logic        not_well_formed_o,
  output logic        at_last_date_o
);

  // split -> leap test
  logic               split_valid;
  logic               split_ready;
  cdi_pkg::cdi_date_t split_data;
  // leap test -> roll-over
  logic               leap_valid;
  logic               leap_ready;
  cdi_pkg::cdi_leap_t leap_data;

  // Stages one to four: range check, month, day and year
  cdi_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .date_i      (packed_date_i),
    .out_valid_o (split_valid),
    .out_ready_i (split_ready),
    .out_o       (split_data)
  );

  // Stages five and six: leap year flag
  cdi_leap u_leap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (split_valid),
    .in_ready_o  (split_ready),
    .in_i        (split_data),
    .out_valid_o (leap_valid),
    .out_ready_i (leap_ready),
    .out_o       (leap_data)
  );

  // Stages seven and eight: advance the day, repack or pass through
  cdi_roll u_roll (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (leap_valid),
    .in_ready_o        (leap_ready),
    .in_i              (leap_data),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .next_date_o       (next_date_o),
    .not_well_formed_o (not_well_formed_o),
    .at_last_date_o    (at_last_date_o)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the packed calendar date increment pipeline.
`timescale 1ns / 1ps

// Drives packed MMDDYYYY words into the date increment pipeline over a
// valid/ready channel and checks every result against a predictor of the
// next-day calculation. The predictor computes the expectation when the
// input transaction is accepted and queues it. A separate process compares
// each output transaction with the oldest queued expectation.
// The directed part covers the range limits, month and year roll-over,
// Gregorian leap years, a day of zero and days past the month length.
// Random dates follow, most of them well-formed with days near the month end.
// Both sides idle at random. One phase runs without idling. In another
// phase the receiver holds off long enough for the pipeline to fill and
// stall its input.
module testbench;

  localparam int unsigned LATENCY        = 8;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [23:0] next_date;
    logic        not_well_formed;
    logic        at_last_date;
  } date_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [23:0] packed_date_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [23:0] next_date_o;
  logic        not_well_formed_o;
  logic        at_last_date_o;

  date_result_t pending_dates[$];
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles   = 0;
  bit           idle_off       = 1'b0;  // both sides run flat out when set
  bit           hold_req       = 1'b0;  // ask the receiver for one long hold-off

  calendar_date_increment uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .packed_date_i    (packed_date_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .next_date_o      (next_date_o),
    .not_well_formed_o(not_well_formed_o),
    .at_last_date_o   (at_last_date_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Gregorian rule: every 4th year, except centuries not divisible by 400
  function automatic bit is_leap(input int unsigned yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
  endfunction

  function automatic int unsigned days_in(input int unsigned mon, input int unsigned yr);
    int unsigned len;
    case (mon)
      4, 6, 9, 11:        len = 30;
      cdi_pkg::MONTH_FEB: len = is_leap(yr) ? 29 : 28;
      default:            len = 31;
    endcase
    return len;
  endfunction

  function automatic logic [23:0] pack_date(input int unsigned mon, input int unsigned day,
                                            input int unsigned yr);
    return 24'(mon * cdi_pkg::MONTH_SCALE + day * cdi_pkg::DAY_SCALE + yr);
  endfunction

  // Work out the day after d, or flag it as out of range or the last date
  function automatic date_result_t next_date_of(input logic [23:0] d);
    date_result_t r;
    int unsigned  mon, day, yr;
    r.next_date       = d;
    r.not_well_formed = 1'b0;
    r.at_last_date    = 1'b0;
    if (d < cdi_pkg::DATE_LOW || d > cdi_pkg::DATE_HIGH) begin
      r.not_well_formed = 1'b1;
      return r;
    end
    mon = d / cdi_pkg::MONTH_SCALE;
    day = (d / cdi_pkg::DAY_SCALE) % 100;
    yr  = d % cdi_pkg::DAY_SCALE;
    // a day of zero or past the month end falls out of the comparison naturally
    if (day < days_in(mon, yr)) begin
      day++;
    end else if (mon < cdi_pkg::MONTH_DEC) begin
      mon++;
      day = 1;
    end else if (yr < cdi_pkg::YEAR_LAST) begin
      yr++;
      mon = 1;
      day = 1;
    end else begin
      r.at_last_date = 1'b1;
      return r;
    end
    r.next_date = pack_date(mon, day, yr);
    return r;
  endfunction

  // Offer one date, after an optional random gap, and queue its expectation
  // once the transaction is accepted. Valid stays high across back-to-back
  // dates so it is never lowered and raised in the same step.
  task automatic send_date(input logic [23:0] d);
    int unsigned gap;
    gap = idle_off ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    packed_date_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    pending_dates.push_back(next_date_of(d));
  endtask

  // Receiver: draw a stall per transaction, with one long hold-off on request
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = idle_off ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin
    date_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_dates.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result next_date=%0d not_well_formed=%0b at_last_date=%0b",
                 $time, next_date_o, not_well_formed_o, at_last_date_o);
      end else begin
        exp_r = pending_dates.pop_front();
        if (next_date_o !== exp_r.next_date) begin
          mismatch_count++;
          $display("%0t: next_date expected %0d actual %0d",
                   $time, exp_r.next_date, next_date_o);
        end
        if (not_well_formed_o !== exp_r.not_well_formed) begin
          mismatch_count++;
          $display("%0t: not_well_formed expected %0b actual %0b (next_date %0d)",
                   $time, exp_r.not_well_formed, not_well_formed_o, exp_r.next_date);
        end
        if (at_last_date_o !== exp_r.at_last_date) begin
          mismatch_count++;
          $display("%0t: at_last_date expected %0b actual %0b (next_date %0d)",
                   $time, exp_r.at_last_date, at_last_date_o, exp_r.next_date);
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Zero, both ends of the accepted range, their neighbours, all ones, near-last dates
  task automatic test_range_edges();
    send_date(24'd0);
    send_date(cdi_pkg::DATE_LOW - 24'd1);
    send_date(cdi_pkg::DATE_LOW);
    send_date(cdi_pkg::DATE_HIGH);
    send_date(cdi_pkg::DATE_HIGH + 24'd1);
    send_date(24'hFFFFFF);
    send_date(pack_date(12, 30, 9999));
    send_date(pack_date(12, 31, 9998));
  endtask

  // Last day of short and long months, November 29, and the December roll into a new year
  task automatic test_month_ends();
    send_date(pack_date(1, 31, 2023));
    send_date(pack_date(4, 30, 2023));
    send_date(pack_date(11, 29, 2023));
    send_date(pack_date(12, 31, 2023));
  endtask

  // February in leap, common, century and four-century years, year zero too
  task automatic test_leap_years();
    send_date(pack_date(2, 28, 2024));
    send_date(pack_date(2, 29, 2024));
    send_date(pack_date(2, 28, 2023));
    send_date(pack_date(2, 28, 1900));
    send_date(pack_date(2, 28, 2000));
    send_date(pack_date(2, 28, 0));
  endtask

  // A day of zero moves to the 1st; a day past the month end rolls over
  task automatic test_odd_days();
    send_date(pack_date(2, 0, 5));
    send_date(pack_date(2, 29, 2023));
    send_date(pack_date(1, 45, 2023));
    send_date(pack_date(4, 31, 1));
    send_date(pack_date(9, 99, 99));
    send_date(pack_date(12, 99, 500));
  endtask

  // Mostly well-formed dates clustered round month ends, the rest raw noise
  task automatic random_date(output logic [23:0] d);
    int unsigned mon, day, yr, pick;
    int unsigned special_years[9] = '{0, 100, 400, 1900, 2000, 2023, 2024, 9998, 9999};
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      d = 24'($urandom_range(0, 24'hFFFFFF));
      return;
    end
    mon = $urandom_range(1, 12);
    yr  = ($urandom_range(0, 9) < 3) ? special_years[$urandom_range(0, 8)]
                                     : $urandom_range(0, 9999);
    pick = $urandom_range(0, 99);
    if (pick < 50)      day = $urandom_range(26, 32);
    else if (pick < 70) day = $urandom_range(0, 99);
    else                day = $urandom_range(1, 31);
    d = pack_date(mon, day, yr);
  endtask

  task automatic test_random_dates(input int unsigned count);
    logic [23:0] d;
    repeat (count) begin
      random_date(d);
      send_date(d);
    end
  endtask

  // Same mix with neither side idling
  task automatic test_full_rate(input int unsigned count);
    idle_off = 1'b1;
    test_random_dates(count);
    idle_off = 1'b0;
  endtask

  // Hold the receiver off while dates keep coming, so the pipeline fills
  task automatic test_backpressure(input int unsigned count);
    hold_req = 1'b1;
    idle_off = 1'b1;
    test_random_dates(count);
    idle_off = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    packed_date_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_range_edges();
    test_month_ends();
    test_leap_years();
    test_odd_days();
    test_random_dates(300);
    test_full_rate(70);
    test_backpressure(80);

    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
